/* rtl/exrm_pkg.sv */
// ----------------------------------------------------------------------------
// exrm_pkg
// Types and constants shared by the Euler XYZ rotation matrix block.
// ----------------------------------------------------------------------------
package exrm_pkg;

  localparam int WORK_FRAC = 30;
  localparam int WW        = 34;
  localparam int OUT_W     = 16;

  localparam logic signed [WW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [WW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [WW-1:0] Q30_GAIN    = 34'sd652032874;

  typedef logic signed [WW-1:0] work_t;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] r0c0;
    logic [OUT_W-1:0] r0c1;
    logic [OUT_W-1:0] r0c2;
    logic [OUT_W-1:0] r1c0;
    logic [OUT_W-1:0] r1c1;
    logic [OUT_W-1:0] r1c2;
    logic [OUT_W-1:0] r2c0;
    logic [OUT_W-1:0] r2c1;
    logic [OUT_W-1:0] r2c2;
  } out_t;

  typedef struct packed {
    work_t x;
    work_t y;
    work_t z;
  } cs_t;

  function automatic work_t atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return work_t'({2'b00, v});
  endfunction

  function automatic work_t qmul(input work_t a, input work_t b);
    logic signed [2*WW-1:0] p;
    p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
    return work_t'(p >>> WORK_FRAC);
  endfunction

endpackage

/* rtl/exrm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// exrm_cordic_cell
// One CORDIC rotation step for the three angles, registered.
// ----------------------------------------------------------------------------
module exrm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             en,
  input  exrm_pkg::cs_t    cs_in [3],
  input  logic [2:0]       flip_in,
  output exrm_pkg::cs_t    cs_out [3],
  output logic [2:0]       flip_out
);

  localparam int SH = (STAGE > 33) ? 33 : STAGE;

  exrm_pkg::cs_t cs_r [3];
  exrm_pkg::cs_t cs_nxt [3];
  logic [2:0]    flip_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!cs_in[k].z[exrm_pkg::WW-1]) begin
        cs_nxt[k].x = cs_in[k].x - (cs_in[k].y >>> SH);
        cs_nxt[k].y = cs_in[k].y + (cs_in[k].x >>> SH);
        cs_nxt[k].z = cs_in[k].z - exrm_pkg::atan_q30(STAGE);
      end else begin
        cs_nxt[k].x = cs_in[k].x + (cs_in[k].y >>> SH);
        cs_nxt[k].y = cs_in[k].y - (cs_in[k].x >>> SH);
        cs_nxt[k].z = cs_in[k].z + exrm_pkg::atan_q30(STAGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r   <= cs_nxt;
      flip_r <= flip_in;
    end
  end

  assign cs_out   = cs_r;
  assign flip_out = flip_r;

endmodule

/* rtl/euler_xyz_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix
// Rotation matrix X*Y*Z from three Euler angles via pipelined CORDIC.
// ----------------------------------------------------------------------------
// One request enters per cycle while the pipe advances. The pipe has one
// range-reduction stage, a row of CORDIC_STAGES cells, two product stages and
// the output register, which also sums, rounds and clamps. The whole pipe
// advances together and stalls only when the output register is full and not
// taken.
module euler_xyz_rotation_matrix #(
  parameter int CORDIC_STAGES   = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  exrm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output exrm_pkg::out_t  out_data
);

  localparam int LAT = CORDIC_STAGES + 3;
  localparam int SH  = exrm_pkg::WORK_FRAC - COEFF_FRAC_BITS;

  logic [LAT-1:0] vld_r;
  logic           adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // range reduction
  exrm_pkg::cs_t cs0_r [3];
  logic [2:0]    flip0_r;
  logic [15:0]   ang [3];
  assign ang[0] = in_data.angle_x;
  assign ang[1] = in_data.angle_y;
  assign ang[2] = in_data.angle_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        cs0_r[k].x <= exrm_pkg::Q30_GAIN;
        cs0_r[k].y <= '0;
        if ((exrm_pkg::work_t'($signed(ang[k])) <<< 17) > exrm_pkg::Q30_HALF_PI) begin
          cs0_r[k].z <= (exrm_pkg::work_t'($signed(ang[k])) <<< 17) - exrm_pkg::Q30_PI;
          flip0_r[k] <= 1'b1;
        end else if ((exrm_pkg::work_t'($signed(ang[k])) <<< 17) < -exrm_pkg::Q30_HALF_PI) begin
          cs0_r[k].z <= (exrm_pkg::work_t'($signed(ang[k])) <<< 17) + exrm_pkg::Q30_PI;
          flip0_r[k] <= 1'b1;
        end else begin
          cs0_r[k].z <= exrm_pkg::work_t'($signed(ang[k])) <<< 17;
          flip0_r[k] <= 1'b0;
        end
      end
    end
  end

  exrm_pkg::cs_t cs_chain [CORDIC_STAGES+1][3];
  logic [2:0]    flip_chain [CORDIC_STAGES+1];
  assign cs_chain[0]   = cs0_r;
  assign flip_chain[0] = flip0_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    exrm_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .en       (adv),
      .cs_in    (cs_chain[g]),
      .flip_in  (flip_chain[g]),
      .cs_out   (cs_chain[g+1]),
      .flip_out (flip_chain[g+1])
    );
  end

  exrm_pkg::work_t s [3];
  exrm_pkg::work_t c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s[k] = flip_chain[CORDIC_STAGES][k] ? -cs_chain[CORDIC_STAGES][k].y
                                          : cs_chain[CORDIC_STAGES][k].y;
      c[k] = flip_chain[CORDIC_STAGES][k] ? -cs_chain[CORDIC_STAGES][k].x
                                          : cs_chain[CORDIC_STAGES][k].x;
    end
  end

  // first products
  exrm_pkg::work_t cycz_r, cysz_r, cxsz_r, czsx_r, cxcz_r, sxsy_r, cysx_r;
  exrm_pkg::work_t sxsz_r, cxsy_r, cxcy_r, sy1_r, sy_z_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cycz_r <= exrm_pkg::qmul(c[1], c[2]);
      cysz_r <= exrm_pkg::qmul(c[1], s[2]);
      cxsz_r <= exrm_pkg::qmul(c[0], s[2]);
      czsx_r <= exrm_pkg::qmul(c[2], s[0]);
      cxcz_r <= exrm_pkg::qmul(c[0], c[2]);
      sxsy_r <= exrm_pkg::qmul(s[0], s[1]);
      cysx_r <= exrm_pkg::qmul(c[1], s[0]);
      sxsz_r <= exrm_pkg::qmul(s[0], s[2]);
      cxsy_r <= exrm_pkg::qmul(c[0], s[1]);
      cxcy_r <= exrm_pkg::qmul(c[0], c[1]);
      sy1_r  <= s[1];
      sy_z_r <= s[2];
    end
  end

  // second products
  exrm_pkg::work_t e_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0] <= cycz_r;
      e_r[1] <= -cysz_r;
      e_r[2] <= sy1_r;
      e_r[3] <= exrm_pkg::qmul(czsx_r, sy1_r);
      e_r[4] <= exrm_pkg::qmul(sxsy_r, sy_z_r);
      e_r[5] <= -cysx_r;
      e_r[6] <= exrm_pkg::qmul(cxcz_r, sy1_r);
      e_r[7] <= exrm_pkg::qmul(cxsy_r, sy_z_r);
      e_r[8] <= cxcy_r;
    end
  end
  exrm_pkg::work_t a_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[3] <= cxsz_r;
      a_r[4] <= cxcz_r;
      a_r[6] <= sxsz_r;
      a_r[7] <= czsx_r;
    end
  end

  // sum, round, clamp
  exrm_pkg::work_t sum [9];
  logic [exrm_pkg::OUT_W-1:0] q [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sum[k] = e_r[k];
    end
    sum[3] = a_r[3] + e_r[3];
    sum[4] = a_r[4] - e_r[4];
    sum[6] = a_r[6] - e_r[6];
    sum[7] = a_r[7] + e_r[7];
    for (int k = 0; k < 9; k++) begin
      sum[k] = (sum[k] + (exrm_pkg::work_t'(1) <<< (SH - 1))) >>> SH;
      if (sum[k] > (exrm_pkg::work_t'(1) <<< COEFF_FRAC_BITS))
        sum[k] = exrm_pkg::work_t'(1) <<< COEFF_FRAC_BITS;
      if (sum[k] < -(exrm_pkg::work_t'(1) <<< COEFF_FRAC_BITS))
        sum[k] = -(exrm_pkg::work_t'(1) <<< COEFF_FRAC_BITS);
      q[k] = sum[k][exrm_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[LAT-2:0], in_valid};
      out_valid <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= '{q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8]};
    end
  end

endmodule
